>>> sv/script_token_scanner_top_macros.svh
`ifndef SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define STS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/sts_pkg.sv
package sts_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int MAX_RESULTS     = 3;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// scan modes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_OP     = 3'd1;
	localparam logic [2:0] MODE_IDENT  = 3'd2;
	localparam logic [2:0] MODE_NUMBER = 3'd3;
	localparam logic [2:0] MODE_STRING = 3'd4;

	// characters
	localparam logic [7:0] CH_D          = 8'h64;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_BANG       = 8'h21;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_AMP        = 8'h26;
	localparam logic [7:0] CH_PIPE       = 8'h7C;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_TILDE      = 8'h7E;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_LBRACE     = 8'h7B;
	localparam logic [7:0] CH_RBRACE     = 8'h7D;
	localparam logic [7:0] CH_LBRACKET   = 8'h5B;
	localparam logic [7:0] CH_RBRACKET   = 8'h5D;
	localparam logic [7:0] CH_LC_A       = 8'h61;
	localparam logic [7:0] CH_LC_Z       = 8'h7A;
	localparam logic [7:0] CH_UC_A       = 8'h41;
	localparam logic [7:0] CH_UC_Z       = 8'h5A;
	localparam logic [7:0] CH_0          = 8'h30;
	localparam logic [7:0] CH_9          = 8'h39;

	// token kinds
	localparam logic [5:0] KIND_ASSIGN     = 6'd0;
	localparam logic [5:0] KIND_EQ_EQ      = 6'd1;
	localparam logic [5:0] KIND_SEMI       = 6'd2;
	localparam logic [5:0] KIND_COLON      = 6'd3;
	localparam logic [5:0] KIND_LPAREN     = 6'd4;
	localparam logic [5:0] KIND_RPAREN     = 6'd5;
	localparam logic [5:0] KIND_COMMA      = 6'd6;
	localparam logic [5:0] KIND_PLUS       = 6'd7;
	localparam logic [5:0] KIND_INC        = 6'd8;
	localparam logic [5:0] KIND_PLUS_EQ    = 6'd9;
	localparam logic [5:0] KIND_MINUS      = 6'd10;
	localparam logic [5:0] KIND_DEC        = 6'd11;
	localparam logic [5:0] KIND_MINUS_EQ   = 6'd12;
	localparam logic [5:0] KIND_NOT        = 6'd13;
	localparam logic [5:0] KIND_NOT_EQ     = 6'd14;
	localparam logic [5:0] KIND_DIV        = 6'd15;
	localparam logic [5:0] KIND_DIV_EQ     = 6'd16;
	localparam logic [5:0] KIND_MUL        = 6'd17;
	localparam logic [5:0] KIND_MUL_EQ     = 6'd18;
	localparam logic [5:0] KIND_LT         = 6'd19;
	localparam logic [5:0] KIND_LT_EQ      = 6'd20;
	localparam logic [5:0] KIND_SHL        = 6'd21;
	localparam logic [5:0] KIND_GT         = 6'd22;
	localparam logic [5:0] KIND_GT_EQ      = 6'd23;
	localparam logic [5:0] KIND_SHR        = 6'd24;
	localparam logic [5:0] KIND_LOG_AND    = 6'd25;
	localparam logic [5:0] KIND_AND        = 6'd26;
	localparam logic [5:0] KIND_LOG_OR     = 6'd27;
	localparam logic [5:0] KIND_OR         = 6'd28;
	localparam logic [5:0] KIND_XOR        = 6'd29;
	localparam logic [5:0] KIND_TILDE      = 6'd30;
	localparam logic [5:0] KIND_MOD        = 6'd31;
	localparam logic [5:0] KIND_MOD_EQ     = 6'd32;
	localparam logic [5:0] KIND_LBRACE     = 6'd33;
	localparam logic [5:0] KIND_RBRACE     = 6'd34;
	localparam logic [5:0] KIND_LBRACKET   = 6'd35;
	localparam logic [5:0] KIND_RBRACKET   = 6'd36;
	localparam logic [5:0] KIND_EOF        = 6'd37;
	localparam logic [5:0] KIND_STRING     = 6'd38;
	localparam logic [5:0] KIND_IDENT      = 6'd39;
	localparam logic [5:0] KIND_DECIMAL    = 6'd40;
	localparam logic [5:0] KIND_INT        = 6'd41;
	localparam logic [5:0] KIND_ILLEGAL    = 6'd42;
	localparam logic [5:0] KIND_NONE       = 6'd63;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic        unterminated;
		logic        last_result;
	} out_item_t;

	// all tokens one source byte gives
	typedef struct packed {
		out_item_t [MAX_RESULTS-1:0] res;
		logic [1:0]                  count;
	} bundle_t;

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z], CH_UNDERSCORE};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_0:CH_9]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SPACE, [CH_TAB:CH_CR]};
	endfunction

	function automatic logic can_pair(input logic [7:0] c);
		return c inside {CH_EQ, CH_PLUS, CH_MINUS, CH_BANG, CH_SLASH, CH_STAR,
			CH_LT, CH_GT, CH_AMP, CH_PIPE, CH_PERCENT};
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] k;
		case (c)
			CH_EQ:       k = KIND_ASSIGN;
			CH_SEMI:     k = KIND_SEMI;
			CH_COLON:    k = KIND_COLON;
			CH_LPAREN:   k = KIND_LPAREN;
			CH_RPAREN:   k = KIND_RPAREN;
			CH_COMMA:    k = KIND_COMMA;
			CH_PLUS:     k = KIND_PLUS;
			CH_MINUS:    k = KIND_MINUS;
			CH_BANG:     k = KIND_NOT;
			CH_SLASH:    k = KIND_DIV;
			CH_STAR:     k = KIND_MUL;
			CH_LT:       k = KIND_LT;
			CH_GT:       k = KIND_GT;
			CH_AMP:      k = KIND_AND;
			CH_PIPE:     k = KIND_OR;
			CH_CARET:    k = KIND_XOR;
			CH_TILDE:    k = KIND_TILDE;
			CH_PERCENT:  k = KIND_MOD;
			CH_LBRACE:   k = KIND_LBRACE;
			CH_RBRACE:   k = KIND_RBRACE;
			CH_LBRACKET: k = KIND_LBRACKET;
			CH_RBRACKET: k = KIND_RBRACKET;
			default:     k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		logic [5:0] k;
		k = KIND_NONE;
		if (b == CH_EQ) begin
			case (a)
				CH_EQ:      k = KIND_EQ_EQ;
				CH_PLUS:    k = KIND_PLUS_EQ;
				CH_MINUS:   k = KIND_MINUS_EQ;
				CH_BANG:    k = KIND_NOT_EQ;
				CH_SLASH:   k = KIND_DIV_EQ;
				CH_STAR:    k = KIND_MUL_EQ;
				CH_LT:      k = KIND_LT_EQ;
				CH_GT:      k = KIND_GT_EQ;
				CH_PERCENT: k = KIND_MOD_EQ;
				default:    k = KIND_NONE;
			endcase
		end else if (a == b) begin
			case (a)
				CH_PLUS:  k = KIND_INC;
				CH_MINUS: k = KIND_DEC;
				CH_LT:    k = KIND_SHL;
				CH_GT:    k = KIND_SHR;
				CH_AMP:   k = KIND_LOG_AND;
				CH_PIPE:  k = KIND_LOG_OR;
				default:  k = KIND_NONE;
			endcase
		end
		return k;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == LEN_MAX) ? LEN_MAX : v + 16'd1;
	endfunction

	function automatic out_item_t mk_item(input logic [5:0] kind, input logic [15:0] start,
			input logic [15:0] len, input logic unterm);
		out_item_t r;
		r.token_kind   = kind;
		r.start_offset = start;
		r.token_length = len;
		r.unterminated = unterm;
		r.last_result  = 1'b0;
		return r;
	endfunction

endpackage

>>> sv/sts_front.sv
module sts_front #(
	parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  sts_pkg::in_item_t src_data,
	input  logic              q_full,
	output logic              q_push,
	output sts_pkg::bundle_t  q_bundle
);

	logic [2:0]             mode_q, mode_d;
	logic [7:0]             held_q, held_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [15:0]            len_q, len_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic                   dot_q, dot_d;
	logic                   endd_q, endd_d;
	logic                   accept;
	sts_pkg::bundle_t       bnd;

	function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	assign src_stall = q_full;
	assign accept    = src_valid && !q_full;
	assign q_push    = accept && (bnd.count != 2'd0);
	assign q_bundle  = bnd;

	always_comb begin
		logic [7:0]             c;
		logic                   fin;
		logic                   consumed;
		logic                   zero_eof;
		logic [1:0]             n;
		logic [5:0]             pk;
		logic [OFFSET_BITS-1:0] pos_inc;
		logic                   close_now;

		c        = src_data.char_code;
		fin      = src_data.end_of_text;
		consumed = 1'b0;
		zero_eof = 1'b0;
		n        = 2'd0;
		pk       = sts_pkg::pair_kind(held_q, c);
		pos_inc  = pos_q + OFFSET_BITS'(1);
		bnd      = '0;
		mode_d   = mode_q;
		held_d   = held_q;
		start_d  = start_q;
		len_d    = len_q;
		dot_d    = dot_q;
		endd_d   = endd_q;
		close_now = 1'b0;

		case (mode_q)
			sts_pkg::MODE_STRING: begin
				len_d = sts_pkg::sat_inc(len_q);
				if (c == sts_pkg::CH_QUOTE) begin
					bnd.res[n] = sts_pkg::mk_item(sts_pkg::KIND_STRING, off16(start_q), len_d, 1'b0);
					n = n + 2'd1;
					mode_d = sts_pkg::MODE_IDLE;
				end
				consumed = 1'b1;
			end
			sts_pkg::MODE_IDENT: begin
				if (sts_pkg::is_letter(c)) begin
					len_d = sts_pkg::sat_inc(len_q);
					consumed = 1'b1;
				end else begin
					close_now = 1'b1;
				end
			end
			sts_pkg::MODE_NUMBER: begin
				if (sts_pkg::is_digit(c) || c == sts_pkg::CH_DOT || c == sts_pkg::CH_D) begin
					len_d = sts_pkg::sat_inc(len_q);
					if (c == sts_pkg::CH_DOT) begin
						dot_d = 1'b1;
					end
					endd_d = (c == sts_pkg::CH_D);
					consumed = 1'b1;
				end else begin
					close_now = 1'b1;
				end
			end
			sts_pkg::MODE_OP: begin
				if (pk != sts_pkg::KIND_NONE) begin
					bnd.res[n] = sts_pkg::mk_item(pk, off16(start_q), 16'd2, 1'b0);
					n = n + 2'd1;
					mode_d = sts_pkg::MODE_IDLE;
					consumed = 1'b1;
				end else begin
					close_now = 1'b1;
				end
			end
			default: begin
				mode_d = sts_pkg::MODE_IDLE;
			end
		endcase

		// close the token this byte breaks off
		if (close_now) begin
			case (mode_q)
				sts_pkg::MODE_IDENT:
					bnd.res[n] = sts_pkg::mk_item(sts_pkg::KIND_IDENT, off16(start_q), len_q, 1'b0);
				sts_pkg::MODE_NUMBER:
					bnd.res[n] = sts_pkg::mk_item((dot_q || endd_q) ? sts_pkg::KIND_DECIMAL
						: sts_pkg::KIND_INT, off16(start_q), len_q, 1'b0);
				default:
					bnd.res[n] = sts_pkg::mk_item(sts_pkg::single_kind(held_q), off16(start_q),
						16'd1, 1'b0);
			endcase
			n = n + 2'd1;
			mode_d = sts_pkg::MODE_IDLE;
		end

		if (!consumed) begin
			if (sts_pkg::is_space(c)) begin
				mode_d = mode_d;
			end else if (c == sts_pkg::CH_NUL) begin
				bnd.res[n] = sts_pkg::mk_item(sts_pkg::KIND_EOF, off16(pos_q), 16'd0, 1'b0);
				n = n + 2'd1;
				zero_eof = 1'b1;
			end else if (c == sts_pkg::CH_QUOTE) begin
				mode_d  = sts_pkg::MODE_STRING;
				start_d = pos_q;
				len_d   = 16'd1;
			end else if (sts_pkg::is_letter(c)) begin
				mode_d  = sts_pkg::MODE_IDENT;
				start_d = pos_q;
				len_d   = 16'd1;
			end else if (sts_pkg::is_digit(c)) begin
				mode_d  = sts_pkg::MODE_NUMBER;
				start_d = pos_q;
				len_d   = 16'd1;
				dot_d   = 1'b0;
				endd_d  = 1'b0;
			end else if (sts_pkg::can_pair(c)) begin
				mode_d  = sts_pkg::MODE_OP;
				held_d  = c;
				start_d = pos_q;
				len_d   = 16'd1;
			end else if (sts_pkg::single_kind(c) != sts_pkg::KIND_NONE) begin
				bnd.res[n] = sts_pkg::mk_item(sts_pkg::single_kind(c), off16(pos_q), 16'd1, 1'b0);
				n = n + 2'd1;
			end else begin
				bnd.res[n] = sts_pkg::mk_item(sts_pkg::KIND_ILLEGAL, off16(pos_q), 16'd1, 1'b0);
				n = n + 2'd1;
			end
		end

		if (fin) begin
			// flush whatever is still open, then mark end of text
			case (mode_d)
				sts_pkg::MODE_IDENT: begin
					bnd.res[n] = sts_pkg::mk_item(sts_pkg::KIND_IDENT, off16(start_d), len_d, 1'b0);
					n = n + 2'd1;
				end
				sts_pkg::MODE_NUMBER: begin
					bnd.res[n] = sts_pkg::mk_item((dot_d || endd_d) ? sts_pkg::KIND_DECIMAL
						: sts_pkg::KIND_INT, off16(start_d), len_d, 1'b0);
					n = n + 2'd1;
				end
				sts_pkg::MODE_OP: begin
					bnd.res[n] = sts_pkg::mk_item(sts_pkg::single_kind(held_d), off16(start_d),
						16'd1, 1'b0);
					n = n + 2'd1;
				end
				sts_pkg::MODE_STRING: begin
					bnd.res[n] = sts_pkg::mk_item(sts_pkg::KIND_STRING, off16(start_d), len_d, 1'b1);
					n = n + 2'd1;
				end
				default: begin
					n = n;
				end
			endcase
			mode_d = sts_pkg::MODE_IDLE;
			if (!zero_eof) begin
				bnd.res[n] = sts_pkg::mk_item(sts_pkg::KIND_EOF, off16(pos_inc), 16'd0, 1'b0);
				n = n + 2'd1;
			end
			pos_d = '0;
		end else begin
			pos_d = pos_inc;
		end

		if (n != 2'd0) begin
			bnd.res[n - 2'd1].last_result = 1'b1;
		end
		bnd.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sts_pkg::MODE_IDLE;
			held_q  <= '0;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			dot_q   <= 1'b0;
			endd_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			held_q  <= held_d;
			start_q <= start_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			dot_q   <= dot_d;
			endd_q  <= endd_d;
		end
	end

endmodule

>>> sv/sts_fifo.sv
`include "script_token_scanner_top_macros.svh"

module sts_fifo #(
	parameter int DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sts_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output sts_pkg::bundle_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sts_pkg::bundle_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`STS_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
	`STS_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty queue")
	`STS_ASSERT_NOW(a_no_empty_bundle, push, push_data.count != 2'd0, "empty bundle queued")

endmodule

>>> sv/sts_back.sv
`include "script_token_scanner_top_macros.svh"

module sts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  sts_pkg::bundle_t   q_head,
	output logic               q_pop,
	output logic               tok_valid,
	input  logic               tok_stall,
	output sts_pkg::out_item_t tok_data
);

	logic [1:0]         idx_q;
	logic               out_valid_q;
	sts_pkg::out_item_t out_q;
	logic               load;
	logic               take;
	logic               last_of;

	assign load    = !out_valid_q || !tok_stall;
	assign take    = load && !q_empty;
	assign last_of = (idx_q == q_head.count - 2'd1);
	assign q_pop   = take && last_of;

	assign tok_valid = out_valid_q;
	assign tok_data  = out_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= q_head.res[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !q_empty;
			end
			// advance within the bundle; drop it after its last token
			if (take) begin
				idx_q <= last_of ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	`STS_ASSERT_NEXT(a_bundle_continues, out_valid_q && !out_q.last_result, out_valid_q,
		"gap inside a token bundle")
	`STS_ASSERT_NOW(a_idx_in_range, !q_empty, idx_q < q_head.count, "bundle index past count")
	`STS_ASSERT_NOW(a_last_on_pop, q_pop, q_head.res[idx_q].last_result,
		"bundle popped before its last token")

endmodule

>>> sv/script_token_scanner_top.sv
// Script token scanner: takes one source byte per cycle on src and sends tokens
// (kind, start offset, length, unterminated flag, last-of-byte flag) on tok. The
// front scanner handles a byte combinationally and needs no gap between bytes;
// it hands the tokens a byte closes, if any (up to three), as one entry into a
// QUEUE_DEPTH-entry queue. The back end sends one token per cycle while tok_stall
// is low, so a byte's tokens leave tok one after another; src stalls only when
// the queue is full. Tokens pass the queue, then the back end's output register.
// Offsets count modulo 2^OFFSET_BITS; end_of_text restarts them at zero.
module script_token_scanner_top #(
	parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH = sts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sts_pkg::in_item_t  src_data,
	output logic               tok_valid,
	input  logic               tok_stall,
	output sts_pkg::out_item_t tok_data
);

	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_empty;
	sts_pkg::bundle_t q_in;
	sts_pkg::bundle_t q_head;

	sts_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_bundle (q_in)
	);

	sts_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	sts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_data (tok_data)
	);

endmodule

>>> test/script_token_scanner_top_tb.sv
`timescale 1ns / 1ps

module script_token_scanner_top_tb;
	import sts_pkg::*;

	localparam int IDLE_LIMIT     = 3000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_BYTES   = 400;
	localparam int LONG_BODY      = 20;

	class token_board;
		out_item_t   pending_tokens[$];
		int          errors;
		logic [2:0]  mode;
		logic [7:0]  held;
		logic [15:0] tok_start;
		logic [15:0] tok_len;
		logic [15:0] pos;
		logic        saw_dot;
		logic        ends_d;

		function new();
			errors    = 0;
			mode      = MODE_IDLE;
			held      = 8'd0;
			tok_start = 16'd0;
			tok_len   = 16'd0;
			pos       = 16'd0;
			saw_dot   = 1'b0;
			ends_d    = 1'b0;
		endfunction

		function logic letter_byte(logic [7:0] c);
			return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
				c == CH_UNDERSCORE;
		endfunction

		function logic digit_byte(logic [7:0] c);
			return c >= CH_0 && c <= CH_9;
		endfunction

		function logic [5:0] lone_kind(logic [7:0] c);
			case (c)
				CH_EQ:       return KIND_ASSIGN;
				CH_SEMI:     return KIND_SEMI;
				CH_COLON:    return KIND_COLON;
				CH_LPAREN:   return KIND_LPAREN;
				CH_RPAREN:   return KIND_RPAREN;
				CH_COMMA:    return KIND_COMMA;
				CH_PLUS:     return KIND_PLUS;
				CH_MINUS:    return KIND_MINUS;
				CH_BANG:     return KIND_NOT;
				CH_SLASH:    return KIND_DIV;
				CH_STAR:     return KIND_MUL;
				CH_LT:       return KIND_LT;
				CH_GT:       return KIND_GT;
				CH_AMP:      return KIND_AND;
				CH_PIPE:     return KIND_OR;
				CH_CARET:    return KIND_XOR;
				CH_TILDE:    return KIND_TILDE;
				CH_PERCENT:  return KIND_MOD;
				CH_LBRACE:   return KIND_LBRACE;
				CH_RBRACE:   return KIND_RBRACE;
				CH_LBRACKET: return KIND_LBRACKET;
				CH_RBRACKET: return KIND_RBRACKET;
				default:     return KIND_NONE;
			endcase
		endfunction

		function void push_token(logic [5:0] kind, logic [15:0] start, logic [15:0] len,
				logic unterm);
			out_item_t t;
			t.token_kind   = kind;
			t.start_offset = start;
			t.token_length = len;
			t.unterminated = unterm;
			t.last_result  = 1'b0;
			pending_tokens.push_back(t);
		endfunction

		function void grow();
			if (tok_len != 16'hFFFF)
				tok_len = tok_len + 16'd1;
		endfunction

		function void close_open();
			case (mode)
				MODE_IDENT:  push_token(KIND_IDENT, tok_start, tok_len, 1'b0);
				MODE_NUMBER: push_token((saw_dot || ends_d) ? KIND_DECIMAL : KIND_INT,
					tok_start, tok_len, 1'b0);
				MODE_OP:     push_token(lone_kind(held), tok_start, 16'd1, 1'b0);
				MODE_STRING: push_token(KIND_STRING, tok_start, tok_len, 1'b1);
				default: ;
			endcase
			mode = MODE_IDLE;
		endfunction

		function void scan_byte(in_item_t it);
			logic [7:0] c;
			logic [5:0] k;
			logic       taken;
			logic       zero_eof;
			int         base;
			c        = it.char_code;
			taken    = 1'b0;
			zero_eof = 1'b0;
			base     = pending_tokens.size();

			case (mode)
				MODE_STRING: begin
					grow();
					if (c == CH_QUOTE) begin
						push_token(KIND_STRING, tok_start, tok_len, 1'b0);
						mode = MODE_IDLE;
					end
					taken = 1'b1;
				end
				MODE_IDENT: begin
					if (letter_byte(c)) begin
						grow();
						taken = 1'b1;
					end else begin
						close_open();
					end
				end
				MODE_NUMBER: begin
					if (digit_byte(c) || c == CH_DOT || c == CH_D) begin
						grow();
						if (c == CH_DOT)
							saw_dot = 1'b1;
						ends_d = (c == CH_D);
						taken  = 1'b1;
					end else begin
						close_open();
					end
				end
				MODE_OP: begin
					k = KIND_NONE;
					if (c == CH_EQ) begin
						case (held)
							CH_EQ:      k = KIND_EQ_EQ;
							CH_PLUS:    k = KIND_PLUS_EQ;
							CH_MINUS:   k = KIND_MINUS_EQ;
							CH_BANG:    k = KIND_NOT_EQ;
							CH_SLASH:   k = KIND_DIV_EQ;
							CH_STAR:    k = KIND_MUL_EQ;
							CH_LT:      k = KIND_LT_EQ;
							CH_GT:      k = KIND_GT_EQ;
							CH_PERCENT: k = KIND_MOD_EQ;
							default:    k = KIND_NONE;
						endcase
					end else if (c == held) begin
						case (held)
							CH_PLUS:  k = KIND_INC;
							CH_MINUS: k = KIND_DEC;
							CH_LT:    k = KIND_SHL;
							CH_GT:    k = KIND_SHR;
							CH_AMP:   k = KIND_LOG_AND;
							CH_PIPE:  k = KIND_LOG_OR;
							default:  k = KIND_NONE;
						endcase
					end
					if (k != KIND_NONE) begin
						push_token(k, tok_start, 16'd2, 1'b0);
						mode  = MODE_IDLE;
						taken = 1'b1;
					end else begin
						close_open();
					end
				end
				default: mode = MODE_IDLE;
			endcase

			if (!taken) begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					// skip whitespace
				end else if (c == CH_NUL) begin
					push_token(KIND_EOF, pos, 16'd0, 1'b0);
					zero_eof = 1'b1;
				end else if (c == CH_QUOTE) begin
					mode      = MODE_STRING;
					tok_start = pos;
					tok_len   = 16'd1;
				end else if (letter_byte(c)) begin
					mode      = MODE_IDENT;
					tok_start = pos;
					tok_len   = 16'd1;
				end else if (digit_byte(c)) begin
					mode      = MODE_NUMBER;
					tok_start = pos;
					tok_len   = 16'd1;
					saw_dot   = 1'b0;
					ends_d    = 1'b0;
				end else if (c inside {CH_EQ, CH_PLUS, CH_MINUS, CH_BANG, CH_SLASH, CH_STAR,
						CH_LT, CH_GT, CH_AMP, CH_PIPE, CH_PERCENT}) begin
					mode      = MODE_OP;
					held      = c;
					tok_start = pos;
					tok_len   = 16'd1;
				end else if (lone_kind(c) != KIND_NONE) begin
					push_token(lone_kind(c), pos, 16'd1, 1'b0);
				end else begin
					push_token(KIND_ILLEGAL, pos, 16'd1, 1'b0);
				end
			end

			if (it.end_of_text) begin
				close_open();
				if (!zero_eof)
					push_token(KIND_EOF, pos + 16'd1, 16'd0, 1'b0);
				pos = 16'd0;
			end else begin
				pos = pos + 16'd1;
			end

			if (pending_tokens.size() > base)
				pending_tokens[pending_tokens.size() - 1].last_result = 1'b1;
		endfunction

		function void match_token(out_item_t got);
			out_item_t w;
			if (pending_tokens.size() == 0) begin
				$error("unexpected token: kind %0d start %0d length %0d", got.token_kind,
					got.start_offset, got.token_length);
				errors++;
				return;
			end
			w = pending_tokens.pop_front();
			if (got.token_kind !== w.token_kind) begin
				$error("token_kind: expected %0d, got %0d", w.token_kind, got.token_kind);
				errors++;
			end
			if (got.start_offset !== w.start_offset) begin
				$error("start_offset: expected %0d, got %0d", w.start_offset, got.start_offset);
				errors++;
			end
			if (got.token_length !== w.token_length) begin
				$error("token_length: expected %0d, got %0d", w.token_length, got.token_length);
				errors++;
			end
			if (got.unterminated !== w.unterminated) begin
				$error("unterminated: expected %0b, got %0b", w.unterminated, got.unterminated);
				errors++;
			end
			if (got.last_result !== w.last_result) begin
				$error("last_result: expected %0b, got %0b", w.last_result, got.last_result);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	in_item_t  src_data = '0;
	logic      tok_valid;
	logic      tok_stall = 1'b0;
	out_item_t tok_data;

	token_board board = new();
	bit         calm = 1'b0;
	bit         squeeze_req = 1'b0;
	bit         squeeze_done = 1'b0;
	int         sent_bytes = 0;

	string op_text[37] = '{"=", "==", ";", ":", "(", ")", ",", "+", "++", "+=", "-", "--",
		"-=", "!", "!=", "/", "/=", "*", "*=", "<", "<=", "<<", ">", ">=", ">>", "&&", "&",
		"||", "|", "^", "~", "%", "%=", "{", "}", "[", "]"};
	string letter_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string number_pool = "0123456789012345..d";

	script_token_scanner_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_byte(logic [7:0] c, logic eot);
		in_item_t it;
		int       gap;
		it.char_code   = c;
		it.end_of_text = eot;
		@(negedge clk);
		src_valid <= 1'b1;
		src_data  <= it;
		do
			@(posedge clk);
		while (src_stall);
		board.scan_byte(it);
		sent_bytes++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			src_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_text(string s, logic eot);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eot && (i == s.len() - 1));
	endtask

	// one random lexical fragment, sometimes closing the text
	task automatic send_fragment();
		logic [7:0] frag[$];
		string      op;
		logic [7:0] b;
		int         r;
		int         n;
		logic       eot;
		eot = ($urandom_range(0, 19) == 0);
		r   = $urandom_range(0, 99);
		if (r < 30) begin
			op = op_text[$urandom_range(0, 36)];
			for (int i = 0; i < op.len(); i++)
				frag.push_back(op[i]);
		end else if (r < 46) begin
			n = $urandom_range(1, 6);
			repeat (n) frag.push_back(letter_pool[$urandom_range(0, letter_pool.len() - 1)]);
		end else if (r < 62) begin
			frag.push_back(8'(CH_0 + $urandom_range(0, 9)));
			n = $urandom_range(0, 4);
			repeat (n) frag.push_back(number_pool[$urandom_range(0, number_pool.len() - 1)]);
			if ($urandom_range(0, 3) == 0)
				frag.push_back(CH_D);
		end else if (r < 74) begin
			frag.push_back(CH_QUOTE);
			n = $urandom_range(0, 6);
			repeat (n) begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == CH_QUOTE);
				if ($urandom_range(0, 9) == 0)
					b = CH_NUL;
				frag.push_back(b);
			end
			if ($urandom_range(0, 99) < 85)
				frag.push_back(CH_QUOTE);
		end else if (r < 84) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				b = 8'($urandom_range(CH_TAB, CH_CR + 1));
				frag.push_back(b == CH_CR + 1 ? CH_SPACE : b);
			end
		end else if (r < 89) begin
			frag.push_back(CH_NUL);
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) frag.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) == 0)
			frag.push_back(CH_SPACE);
		for (int i = 0; i < frag.size(); i++)
			send_byte(frag[i], eot && (i == frag.size() - 1));
	endtask

	// receiver: random stall runs, one long hold-off on request
	initial begin
		int hold;
		forever begin
			hold = pick_gap();
			if (squeeze_req && !squeeze_done) begin
				hold         = SQUEEZE_CYCLES;
				squeeze_done = 1'b1;
			end
			repeat (hold) begin
				@(negedge clk);
				tok_stall <= 1'b1;
			end
			repeat ($urandom_range(1, 10)) begin
				@(negedge clk);
				tok_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall)
			board.match_token(tok_data);
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
				idle = 0;
			else
				idle++;
		end
		$display("script_token_scanner_top_tb: FAIL");
		$finish;
	end

	initial begin
		int base;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// identifiers, numbers, pairs, zero byte, high bytes, string with zero byte
		send_text("_aZ 1.5 7d 42 ==+=", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_text("\"q", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte("x", 1'b1);
		send_byte(CH_NUL, 1'b1);

		// longer string between identifiers, bytes back to back
		calm = 1'b1;
		send_text("ab ", 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		repeat (LONG_BODY) send_byte("x", 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_text("ab", 1'b1);
		calm = 1'b0;

		base        = sent_bytes;
		squeeze_req = 1'b1;
		while (sent_bytes - base < RANDOM_BYTES) begin
			if ($urandom_range(0, 39) == 0)
				calm = ~calm;
			send_fragment();
		end
		calm = 1'b0;
		send_byte(CH_SPACE, 1'b1);
		@(negedge clk);
		src_valid <= 1'b0;

		while (board.pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_tokens.size() == 0)
			$display("script_token_scanner_top_tb: PASS");
		else
			$display("script_token_scanner_top_tb: FAIL");
		$finish;
	end

endmodule
